FILE: hdl/asgc_pkg.sv
// ----------------------------------------------------------------------------
// asgc_pkg
// Shared types, constants and saturation helper for the anti-sway controller.
// ----------------------------------------------------------------------------
package asgc_pkg;

	localparam int DataW   = 32;
	localparam int GainW   = 24;
	localparam int BandW   = 31;
	localparam int CfgIdxW = 3;
	localparam int ProdW   = DataW + GainW + 1;
	localparam int AccW    = ProdW + 2;
	localparam int RndW    = AccW - 16;
	localparam int StateW  = 4;

	localparam logic [CfgIdxW-1:0] REG_POSITION_GAIN       = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_VELOCITY_GAIN       = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ANGLE_COEF_CURRENT  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ANGLE_COEF_PREVIOUS = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ANGLE_COEF_FEEDBACK = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_ANGLE_DEAD_BAND     = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_VELOCITY_DEAD_BAND  = 3'd6;

	localparam logic [GainW-1:0] RST_POSITION_GAIN       = 24'd196608;
	localparam logic [GainW-1:0] RST_VELOCITY_GAIN       = 24'd393216;
	localparam logic [GainW-1:0] RST_ANGLE_COEF_CURRENT  = 24'd9568256;
	localparam logic [GainW-1:0] RST_ANGLE_COEF_PREVIOUS = 24'd9011200;
	localparam logic [GainW-1:0] RST_ANGLE_COEF_FEEDBACK = 24'd48438;
	localparam logic [BandW-1:0] RST_ANGLE_DEAD_BAND     = 31'd1966;
	localparam logic [BandW-1:0] RST_VELOCITY_DEAD_BAND  = 31'd1311;

	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_SUB  = 2'd2;

	typedef struct packed {
		logic       mul_en;
		logic [1:0] acc_op;
	} mac_cmd_t;

	typedef struct packed {
		logic [GainW-1:0] position_gain;
		logic [GainW-1:0] velocity_gain;
		logic [GainW-1:0] angle_coef_current;
		logic [GainW-1:0] angle_coef_previous;
		logic [GainW-1:0] angle_coef_feedback;
		logic [BandW-1:0] angle_dead_band;
		logic [BandW-1:0] velocity_dead_band;
	} cfg_t;

	typedef struct packed {
		logic [DataW-1:0] value;
		logic             clip;
	} sat_t;

	function automatic sat_t sat_to_32(input logic signed [RndW-1:0] v);
		sat_t r;
		if ((&v[RndW-1:DataW-1]) || !(|v[RndW-1:DataW-1])) begin
			r.value = v[DataW-1:0];
			r.clip  = 1'b0;
		end else if (v[RndW-1]) begin
			r.value = {1'b1, {(DataW-1){1'b0}}};
			r.clip  = 1'b1;
		end else begin
			r.value = {1'b0, {(DataW-1){1'b1}}};
			r.clip  = 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: hdl/asgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// asgc_cfg_regs
// Gain, coefficient and dead band registers with a plain write port.
// ----------------------------------------------------------------------------
module asgc_cfg_regs
	import asgc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [BandW-1:0]   cfg_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.position_gain       <= RST_POSITION_GAIN;
			cfg_q.velocity_gain       <= RST_VELOCITY_GAIN;
			cfg_q.angle_coef_current  <= RST_ANGLE_COEF_CURRENT;
			cfg_q.angle_coef_previous <= RST_ANGLE_COEF_PREVIOUS;
			cfg_q.angle_coef_feedback <= RST_ANGLE_COEF_FEEDBACK;
			cfg_q.angle_dead_band     <= RST_ANGLE_DEAD_BAND;
			cfg_q.velocity_dead_band  <= RST_VELOCITY_DEAD_BAND;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_POSITION_GAIN:       cfg_q.position_gain       <= cfg_data[GainW-1:0];
				REG_VELOCITY_GAIN:       cfg_q.velocity_gain       <= cfg_data[GainW-1:0];
				REG_ANGLE_COEF_CURRENT:  cfg_q.angle_coef_current  <= cfg_data[GainW-1:0];
				REG_ANGLE_COEF_PREVIOUS: cfg_q.angle_coef_previous <= cfg_data[GainW-1:0];
				REG_ANGLE_COEF_FEEDBACK: cfg_q.angle_coef_feedback <= cfg_data[GainW-1:0];
				REG_ANGLE_DEAD_BAND:     cfg_q.angle_dead_band     <= cfg_data;
				REG_VELOCITY_DEAD_BAND:  cfg_q.velocity_dead_band  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/asgc_mac.sv
// ----------------------------------------------------------------------------
// asgc_mac
// Shared multiply-accumulate unit with round-half-up and 32-bit saturation.
// ----------------------------------------------------------------------------
module asgc_mac
	import asgc_pkg::*;
(
	input  logic                    clk,
	input  mac_cmd_t                cmd,
	input  logic signed [DataW-1:0] mul_a,
	input  logic [GainW-1:0]        mul_b,
	output sat_t                    rnd
);

	logic signed [ProdW-1:0] prod_q;
	logic signed [AccW-1:0]  acc_q;
	logic signed [AccW-1:0]  acc_bias;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= ProdW'(mul_a * $signed({1'b0, mul_b}));
		end
		unique case (cmd.acc_op)
			ACC_LOAD: acc_q <= AccW'(prod_q);
			ACC_SUB:  acc_q <= acc_q - AccW'(prod_q);
			default:  acc_q <= acc_q;
		endcase
	end

	assign acc_bias = acc_q + AccW'(32768);
	assign rnd      = sat_to_32(acc_bias[AccW-1:16]);

endmodule

FILE: hdl/antisway_gantry_controller.sv
// ----------------------------------------------------------------------------
// antisway_gantry_controller
// Anti-sway lead compensator with a proportional position and velocity loop.
// ----------------------------------------------------------------------------
// Each input transfer is one control tick and yields one output transfer. A
// sequencer runs every product of the tick through a single 32x24 multiplier
// and accumulator, from the error step through to the result step. The next
// input is taken once the sequencer is back in idle, which happens as soon as
// the result sits in the output register, so a tick is not taken before the
// last one is through. A result still waiting in the output register holds
// the sequencer in its last step until the output side takes it.
module antisway_gantry_controller
	import asgc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [BandW-1:0]   cfg_data,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// reference_position, measured_position, measured_angle, measured_velocity
	input  logic [127:0]       s_axis_tdata,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// drive_value, position_term, angle_term
	output logic [95:0]        m_axis_tdata,
	// saturated_flag
	output logic               m_axis_tuser
);

	localparam logic [StateW-1:0] ST_IDLE = 4'd0;
	localparam logic [StateW-1:0] ST_ERR  = 4'd1;
	localparam logic [StateW-1:0] ST_MPOS = 4'd2;
	localparam logic [StateW-1:0] ST_LPOS = 4'd3;
	localparam logic [StateW-1:0] ST_RPOS = 4'd4;
	localparam logic [StateW-1:0] ST_B1   = 4'd5;
	localparam logic [StateW-1:0] ST_A1   = 4'd6;
	localparam logic [StateW-1:0] ST_U    = 4'd7;
	localparam logic [StateW-1:0] ST_NEG  = 4'd8;
	localparam logic [StateW-1:0] ST_VERR = 4'd9;
	localparam logic [StateW-1:0] ST_MVG  = 4'd10;
	localparam logic [StateW-1:0] ST_LVG  = 4'd11;
	localparam logic [StateW-1:0] ST_OUT  = 4'd12;

	cfg_t cfg;
	mac_cmd_t mac_cmd;
	sat_t mac_rnd;
	logic signed [DataW-1:0] mul_a;
	logic [GainW-1:0] mul_b;

	logic [StateW-1:0] state_q;
	logic [DataW-1:0] ref_q, pos_q, ang_q, vel_q;
	logic [DataW-1:0] pos_err_q, ang_err_q, pos_term_q, u_q, ang_term_q, vel_err_q;
	logic [DataW-1:0] prev_err_q, prev_u_q;
	logic dead_q, clip_q;
	logic m_valid_q;
	logic [DataW-1:0] m_drive_q, m_pos_q, m_ang_q;
	logic m_flag_q;

	logic signed [DataW:0] pos_diff, ang_neg, u_neg;
	logic signed [DataW+1:0] vel_sum;
	sat_t pos_sat, ang_sat, neg_sat, vel_sat;
	logic [DataW-1:0] ang_mag, vel_mag;
	logic out_free;

	asgc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	asgc_mac u_mac (
		.clk   (clk),
		.cmd   (mac_cmd),
		.mul_a (mul_a),
		.mul_b (mul_b),
		.rnd   (mac_rnd)
	);

	assign pos_diff = {ref_q[DataW-1], ref_q} - {pos_q[DataW-1], pos_q};
	assign ang_neg  = (DataW+1)'(0) - {ang_q[DataW-1], ang_q};
	assign u_neg    = (DataW+1)'(0) - {u_q[DataW-1], u_q};
	assign vel_sum  = {{2{ang_term_q[DataW-1]}}, ang_term_q}
		+ {{2{pos_term_q[DataW-1]}}, pos_term_q}
		- {{2{vel_q[DataW-1]}}, vel_q};

	assign pos_sat = sat_to_32(RndW'(pos_diff));
	assign ang_sat = sat_to_32(RndW'(ang_neg));
	assign neg_sat = sat_to_32(RndW'(u_neg));
	assign vel_sat = sat_to_32(RndW'(vel_sum));

	assign ang_mag = ang_sat.value[DataW-1] ? (DataW)'(0) - ang_sat.value : ang_sat.value;
	assign vel_mag = vel_sat.value[DataW-1] ? (DataW)'(0) - vel_sat.value : vel_sat.value;

	assign out_free = !m_valid_q || m_axis_tready;

	always_comb begin
		mac_cmd.mul_en = 1'b0;
		mac_cmd.acc_op = ACC_HOLD;
		mul_a = pos_err_q;
		mul_b = cfg.position_gain;
		unique case (state_q)
			ST_MPOS: begin
				mac_cmd.mul_en = 1'b1;
			end
			ST_LPOS: begin
				mac_cmd.mul_en = 1'b1;
				mac_cmd.acc_op = ACC_LOAD;
				mul_a = ang_err_q;
				mul_b = cfg.angle_coef_current;
			end
			ST_RPOS: begin
				mac_cmd.mul_en = 1'b1;
				mac_cmd.acc_op = ACC_LOAD;
				mul_a = prev_err_q;
				mul_b = cfg.angle_coef_previous;
			end
			ST_B1: begin
				mac_cmd.mul_en = 1'b1;
				mac_cmd.acc_op = ACC_SUB;
				mul_a = prev_u_q;
				mul_b = cfg.angle_coef_feedback;
			end
			ST_A1: begin
				mac_cmd.acc_op = ACC_SUB;
			end
			ST_MVG: begin
				mac_cmd.mul_en = 1'b1;
				mul_a = vel_err_q;
				mul_b = cfg.velocity_gain;
			end
			ST_LVG: begin
				mac_cmd.acc_op = ACC_LOAD;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					ref_q <= s_axis_tdata[31:0];
					pos_q <= s_axis_tdata[63:32];
					ang_q <= s_axis_tdata[95:64];
					vel_q <= s_axis_tdata[127:96];
				end
			end
			ST_ERR: begin
				pos_err_q <= pos_sat.value;
				ang_err_q <= (ang_mag < {1'b0, cfg.angle_dead_band}) ? '0 : ang_sat.value;
			end
			ST_RPOS: pos_term_q <= mac_rnd.value;
			ST_U:    u_q <= mac_rnd.value;
			ST_NEG:  ang_term_q <= neg_sat.value;
			ST_VERR: begin
				vel_err_q <= vel_sat.value;
				dead_q    <= vel_mag < {1'b0, cfg.velocity_dead_band};
			end
			default: begin
			end
		endcase
		if (state_q == ST_OUT && out_free) begin
			m_drive_q <= dead_q ? '0 : mac_rnd.value;
			m_pos_q   <= pos_term_q;
			m_ang_q   <= ang_term_q;
			m_flag_q  <= clip_q || (!dead_q && mac_rnd.clip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clip_q     <= 1'b0;
			prev_err_q <= '0;
			prev_u_q   <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_ERR;
						clip_q  <= 1'b0;
					end
				end
				ST_ERR: begin
					clip_q  <= pos_sat.clip || ang_sat.clip;
					state_q <= ST_MPOS;
				end
				ST_MPOS: state_q <= ST_LPOS;
				ST_LPOS: state_q <= ST_RPOS;
				ST_RPOS: begin
					clip_q  <= clip_q || mac_rnd.clip;
					state_q <= ST_B1;
				end
				ST_B1:   state_q <= ST_A1;
				ST_A1:   state_q <= ST_U;
				ST_U: begin
					clip_q     <= clip_q || mac_rnd.clip;
					prev_err_q <= ang_err_q;
					prev_u_q   <= mac_rnd.value;
					state_q    <= ST_NEG;
				end
				ST_NEG: begin
					clip_q  <= clip_q || neg_sat.clip;
					state_q <= ST_VERR;
				end
				ST_VERR: begin
					clip_q  <= clip_q || vel_sat.clip;
					state_q <= ST_MVG;
				end
				ST_MVG:  state_q <= ST_LVG;
				ST_LVG:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {m_ang_q, m_pos_q, m_drive_q};
	assign m_axis_tuser  = m_flag_q;

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_ERR))
		else $error("Accepted input did not start the sequencer.");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == ST_OUT))
		else $error("Output valid rose outside the result state.");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && m_axis_tvalid && !m_axis_tready) |=> (state_q == ST_OUT))
		else $error("Sequencer left the result state while the output was stalled.");

endmodule
